### src/acs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Autorange current selector package
// Shared types, widths and codes for the autorange current selector.
// ----------------------------------------------------------------------------
package acs_pkg;

  // Rows per chunk and the widths that follow from it.
  localparam int CHUNK_ROWS = 100;
  localparam int POS_W      = (CHUNK_ROWS > 1) ? $clog2(CHUNK_ROWS) : 1;
  localparam int ACC_CNT_W  = $clog2(CHUNK_ROWS + 1);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(CHUNK_ROWS - 1);

  localparam int SAMPLE_W = 12;
  localparam int CNT_W    = 8;
  localparam int ACC_W    = 7;
  localparam int CFG_IDX_W = 2;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_OVER_THR    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UNDER_THR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_CNT = 2'd2;

  // Configuration reset values.
  localparam logic [SAMPLE_W-1:0] OVER_THR_RST    = 12'd3800;
  localparam logic [SAMPLE_W-1:0] UNDER_THR_RST   = 12'd100;
  localparam logic [CNT_W-1:0]    CONFIRM_CNT_RST = 8'd5;

  typedef enum logic [1:0] {
    RANGE_LOW  = 2'd0,
    RANGE_MID  = 2'd1,
    RANGE_HIGH = 2'd2
  } range_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] over_thr;
    logic [SAMPLE_W-1:0] under_thr;
    logic [CNT_W-1:0]    confirm;
  } cfg_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] vol;
    logic [SAMPLE_W-1:0] lo;
    logic [SAMPLE_W-1:0] mid;
    logic [SAMPLE_W-1:0] hi;
    logic [SAMPLE_W-1:0] ref_smp;
  } row_t;

  typedef struct packed {
    range_t               active_range;
    logic [CNT_W-1:0]     over_count;
    logic [CNT_W-1:0]     under_count;
    logic                 discard_chunk;
    logic                 switch_pending;
    range_t               requested_range;
    logic [POS_W-1:0]     row_position;
    logic [ACC_CNT_W-1:0] rows_accepted;
  } state_t;

  typedef struct packed {
    logic                sample_valid;
    logic [1:0]          range_code;
    logic [SAMPLE_W-1:0] vol_out;
    logic [SAMPLE_W-1:0] current_out;
    logic [SAMPLE_W-1:0] ref_out;
    logic                chunk_end;
    logic [ACC_W-1:0]    accepted_count;
    logic                range_switch;
    logic [1:0]          next_range;
  } result_t;

endpackage
`default_nettype wire

### src/acs_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Autorange current selector row step
// Combinational evaluation of one scan row: range compare, debounce counters,
// chunk bookkeeping and the result item.
// ----------------------------------------------------------------------------
module acs_step (
  input  acs_pkg::cfg_t    cfg,
  input  acs_pkg::state_t  st,
  input  acs_pkg::row_t    row,
  output acs_pkg::state_t  st_next,
  output acs_pkg::result_t res
);

  logic [acs_pkg::SAMPLE_W-1:0]  sel;
  logic [acs_pkg::SAMPLE_W-1:0]  diff;
  logic                          over;
  logic                          under;
  logic [acs_pkg::CNT_W-1:0]     over_inc;
  logic [acs_pkg::CNT_W-1:0]     under_inc;
  logic                          last;
  logic                          pass;
  acs_pkg::range_t               req;
  logic [acs_pkg::ACC_CNT_W-1:0] acc_cnt;
  logic [31:0]                   acc_ext;

  assign last = (st.row_position == acs_pkg::POS_LAST);

  always_comb begin
    case (st.active_range)
      acs_pkg::RANGE_LOW: sel = row.lo;
      acs_pkg::RANGE_MID: sel = row.mid;
      default:            sel = row.hi;
    endcase
  end

  assign diff      = (sel >= row.ref_smp) ? (sel - row.ref_smp) : (row.ref_smp - sel);
  assign over      = (diff >= cfg.over_thr);
  assign under     = (diff < cfg.under_thr);
  assign over_inc  = (st.over_count == acs_pkg::CNT_MAX) ? acs_pkg::CNT_MAX
                                                         : st.over_count + 1'b1;
  assign under_inc = (st.under_count == acs_pkg::CNT_MAX) ? acs_pkg::CNT_MAX
                                                          : st.under_count + 1'b1;

  always_comb begin
    st_next = st;
    pass    = 1'b0;
    req     = st.active_range;

    if (st.discard_chunk) begin
      st_next.over_count  = '0;
      st_next.under_count = '0;
    end else if (!st.switch_pending) begin
      case (st.active_range)
        acs_pkg::RANGE_LOW: begin
          st_next.over_count  = over ? over_inc : '0;
          st_next.under_count = '0;
          if (over && (over_inc >= cfg.confirm)) req = acs_pkg::RANGE_MID;
        end
        acs_pkg::RANGE_MID: begin
          st_next.over_count  = over ? over_inc : '0;
          st_next.under_count = under ? under_inc : '0;
          // Underload wins when both are confirmed on the same row.
          if (over && (over_inc >= cfg.confirm)) req = acs_pkg::RANGE_HIGH;
          if (under && (under_inc >= cfg.confirm)) req = acs_pkg::RANGE_LOW;
        end
        default: begin
          st_next.under_count = under ? under_inc : '0;
          st_next.over_count  = '0;
          if (under && (under_inc >= cfg.confirm)) req = acs_pkg::RANGE_MID;
        end
      endcase

      if (req != st.active_range) begin
        st_next.switch_pending  = 1'b1;
        st_next.requested_range = req;
      end else begin
        pass                  = 1'b1;
        st_next.rows_accepted = st.rows_accepted + 1'b1;
      end
    end

    acc_cnt = st_next.rows_accepted;

    if (last) begin
      if (st.discard_chunk) begin
        st_next.discard_chunk = 1'b0;
      end else if (st_next.switch_pending) begin
        st_next.active_range   = st_next.requested_range;
        st_next.discard_chunk  = 1'b1;
        st_next.switch_pending = 1'b0;
        st_next.over_count     = '0;
        st_next.under_count    = '0;
      end
      st_next.rows_accepted = '0;
      st_next.row_position  = '0;
    end else begin
      st_next.row_position = st.row_position + 1'b1;
    end
  end

  assign acc_ext = 32'(acc_cnt);

  always_comb begin
    res.sample_valid   = pass;
    res.range_code     = st.active_range;
    res.vol_out        = pass ? row.vol : '0;
    res.current_out    = pass ? sel : '0;
    res.ref_out        = pass ? row.ref_smp : '0;
    res.chunk_end      = last;
    res.accepted_count = '0;
    res.range_switch   = 1'b0;
    if (last && !st.discard_chunk) begin
      res.accepted_count = (acc_ext > 32'(acs_pkg::ACC_MAX)) ? acs_pkg::ACC_MAX
                                                             : acc_ext[acs_pkg::ACC_W-1:0];
      res.range_switch   = st_next.discard_chunk;
    end
    res.next_range = st_next.active_range;
  end

endmodule
`default_nettype wire

### src/autorange_current_selector.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Autorange current selector
// Picks the current sample of the active range for each scan row, debounces
// overload and underload against programmable thresholds, and switches range
// at chunk borders, dropping the chunk that follows a switch.
// ----------------------------------------------------------------------------
//
//  Channel  | Signals                                   | Direction
//  ---------+-------------------------------------------+----------
//  input    | in_valid/in_ready, five 12-bit samples    | in
//  result   | out_valid/out_ready, nine result fields   | out
//  config   | cfg_valid/cfg_ready, cfg_index, cfg_data  | in
//
// One row is taken per cycle unless the result stalls; a row moves from the
// input register into the result register when that is empty or taken.
// Reset (rst, synchronous) restores the configuration defaults, empties both
// registers and starts a chunk on the high range.
// A stalled result holds the input register; in_ready drops only while both
// registers are full and the result is not taken.
//
module autorange_current_selector (
  input  logic                         clk,
  input  logic                         rst,

  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [acs_pkg::SAMPLE_W-1:0] vol_sample,
  input  logic [acs_pkg::SAMPLE_W-1:0] low_range_sample,
  input  logic [acs_pkg::SAMPLE_W-1:0] mid_range_sample,
  input  logic [acs_pkg::SAMPLE_W-1:0] high_range_sample,
  input  logic [acs_pkg::SAMPLE_W-1:0] ref_sample,

  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         sample_valid,
  output logic [1:0]                   range_code,
  output logic [acs_pkg::SAMPLE_W-1:0] vol_out,
  output logic [acs_pkg::SAMPLE_W-1:0] current_out,
  output logic [acs_pkg::SAMPLE_W-1:0] ref_out,
  output logic                         chunk_end,
  output logic [acs_pkg::ACC_W-1:0]    accepted_count,
  output logic                         range_switch,
  output logic [1:0]                   next_range,

  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [acs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [acs_pkg::SAMPLE_W-1:0] cfg_data
);

  acs_pkg::cfg_t    cfg;
  acs_pkg::state_t  st;
  acs_pkg::state_t  st_next;
  acs_pkg::row_t    row_reg;
  acs_pkg::result_t res_next;
  acs_pkg::result_t res_reg;
  logic             row_valid;
  logic             advance;

  // The input register moves forward whenever the result register is empty
  // or its transaction completes in this cycle.
  assign advance  = row_valid && (!out_valid || out_ready);
  assign in_ready = !row_valid || advance;

  // Configuration writes are always taken; the user must write only while the
  // block is idle (unenforced). Data beyond a register's width is dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.over_thr  <= acs_pkg::OVER_THR_RST;
      cfg.under_thr <= acs_pkg::UNDER_THR_RST;
      cfg.confirm   <= acs_pkg::CONFIRM_CNT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        acs_pkg::CFG_OVER_THR:    cfg.over_thr  <= cfg_data;
        acs_pkg::CFG_UNDER_THR:   cfg.under_thr <= cfg_data;
        acs_pkg::CFG_CONFIRM_CNT: cfg.confirm   <= cfg_data[acs_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= 1'b0;
    end else if (in_ready) begin
      row_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      row_reg.vol     <= vol_sample;
      row_reg.lo      <= low_range_sample;
      row_reg.mid     <= mid_range_sample;
      row_reg.hi      <= high_range_sample;
      row_reg.ref_smp <= ref_sample;
    end
  end

  acs_step u_step (
    .cfg     (cfg),
    .st      (st),
    .row     (row_reg),
    .st_next (st_next),
    .res     (res_next)
  );

  // Range and debounce state, updated once per evaluated row.
  always_ff @(posedge clk) begin
    if (rst) begin
      st.active_range    <= acs_pkg::RANGE_HIGH;
      st.over_count      <= '0;
      st.under_count     <= '0;
      st.discard_chunk   <= 1'b0;
      st.switch_pending  <= 1'b0;
      st.requested_range <= acs_pkg::RANGE_HIGH;
      st.row_position    <= '0;
      st.rows_accepted   <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= advance || (out_valid && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_reg <= res_next;
    end
  end

  assign sample_valid   = res_reg.sample_valid;
  assign range_code     = res_reg.range_code;
  assign vol_out        = res_reg.vol_out;
  assign current_out    = res_reg.current_out;
  assign ref_out        = res_reg.ref_out;
  assign chunk_end      = res_reg.chunk_end;
  assign accepted_count = res_reg.accepted_count;
  assign range_switch   = res_reg.range_switch;
  assign next_range     = res_reg.next_range;

endmodule
`default_nettype wire
